@@ sv/fpfa_pkg.sv @@
package fpfa_pkg;

    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2
    } fit_policy_t;

    // Broadcast commands from the controller to every cell
    typedef struct packed {
        logic        load;
        logic        grant;
        fit_policy_t policy;
    } cmd_t;

    // Register select bit of paddr: 0 fit_policy, 1 partitions_in_use
    localparam logic REG_FIT_POLICY = 1'b0;
    localparam logic REG_PARTS      = 1'b1;

    localparam int PARTS_W      = 5;
    localparam int IN_IDX_W     = 4;
    localparam int FIELD_SIZE_W = 16;

endpackage

@@ sv/fpfa_cell.sv @@
module fpfa_cell #(
    parameter int IDX       = 0,
    parameter int IW        = 4,
    parameter int SIZE_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  fpfa_pkg::cmd_t                 cmd,
    input  logic [fpfa_pkg::IN_IDX_W-1:0]  load_idx,
    input  logic [SIZE_BITS-1:0]           load_size,
    input  logic [IW-1:0]                  grant_idx,
    input  logic [fpfa_pkg::PARTS_W-1:0]   lim,
    input  logic [SIZE_BITS-1:0]           req,
    input  logic                           tin_valid,
    input  logic                           tin_found,
    input  logic [IW-1:0]                  tin_pick,
    input  logic [SIZE_BITS-1:0]           tin_size,
    output logic                           tout_valid,
    output logic                           tout_found,
    output logic [IW-1:0]                  tout_pick,
    output logic [SIZE_BITS-1:0]           tout_size
);
    import fpfa_pkg::*;

    logic                 busy_reg;
    logic                 busy_next;
    logic [SIZE_BITS-1:0] size_reg;
    logic                 tok_valid_reg;
    logic                 tok_found_reg;
    logic [IW-1:0]        tok_pick_reg;
    logic [SIZE_BITS-1:0] tok_size_reg;
    logic                 in_scope;
    logic                 fits;
    logic                 better;
    logic                 take;
    logic                 load_hit;

    always_comb
    begin
        load_hit = cmd.load && (int'(load_idx) == IDX);
        in_scope = (IDX < int'(lim));
        fits     = !busy_reg && (size_reg >= req);
        case (cmd.policy)
            FIT_FIRST: better = !tin_found;
            FIT_BEST:  better = !tin_found || (size_reg <= tin_size);
            FIT_WORST: better = !tin_found || (size_reg >= tin_size);
            default:   better = 1'b0;
        endcase
        take = tin_valid && in_scope && fits && better;

        busy_next = busy_reg;
        if (load_hit)
        begin
            busy_next = 1'b0;
        end
        else if (cmd.grant && (int'(grant_idx) == IDX))
        begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            tok_valid_reg <= tin_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_hit)
        begin
            size_reg <= load_size;
        end
        // Replace the running pick when this partition wins
        if (take)
        begin
            tok_found_reg <= 1'b1;
            tok_pick_reg  <= IW'(IDX);
            tok_size_reg  <= size_reg;
        end
        else
        begin
            tok_found_reg <= tin_found;
            tok_pick_reg  <= tin_pick;
            tok_size_reg  <= tin_size;
        end
    end

    assign tout_valid = tok_valid_reg;
    assign tout_found = tok_found_reg;
    assign tout_pick  = tok_pick_reg;
    assign tout_size  = tok_size_reg;

endmodule

@@ sv/fixed_partition_fit_allocator.sv @@
// Fixed-partition allocator: a table of partition sizes, each with a busy flag.
// Input channel s_*: s_tuser is the mode (0 load a partition size, 1 request).
//   A load writes the size and frees the partition; its result echoes the index.
//   A request is matched against the free partitions by the fit policy.
// Output channel m_*: one result item per input item; m_tuser is granted.
// Configuration over APB: fit_policy at 0x0, partitions_in_use at 0x4.
// Sequence: a load's result is registered, then moves into the output register;
//   a request starts a search token that walks the row of partition cells one
//   cell per cycle, and its result is registered when the token leaves the row.
// Throughput: one item at a time; a new item is taken once the previous result
//   has moved into the output register. A new item may be taken while the
//   previous result still waits in the output register.
// Reset clears all busy flags, the fit policy to first fit and
//   partitions_in_use to 16; sizes are undefined until loaded.
// When the receiver stalls, the result holds in the output register and a
//   finished next result waits until it drains.
module fixed_partition_fit_allocator #(
    parameter int PARTITIONS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [3:0] partition_index, [19:4] partition_size, [35:20] request_size
    input  logic [39:0] s_tdata,
    // [0] mode
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] granted_index, [19:4] granted_size
    output logic [23:0] m_tdata,
    // [0] granted
    output logic        m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fpfa_pkg::*;

    localparam int IW = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    fit_policy_t             policy_reg;
    logic [PARTS_W-1:0]      parts_reg;
    logic [SIZE_BITS-1:0]    req_reg;
    logic                    start_reg;
    logic                    res_granted_reg;
    logic [IN_IDX_W-1:0]     res_idx_reg;
    logic [FIELD_SIZE_W-1:0] res_size_reg;
    logic                    m_valid_reg;
    logic                    m_valid_next;
    logic                    m_granted_reg;
    logic [IN_IDX_W-1:0]     m_idx_reg;
    logic [FIELD_SIZE_W-1:0] m_size_reg;

    logic                    in_fire;
    logic                    in_mode;
    logic [IN_IDX_W-1:0]     in_pidx;
    logic [SIZE_BITS-1:0]    in_psize;
    logic [SIZE_BITS-1:0]    in_req;
    logic                    scan_done;
    logic                    slot_free;
    logic                    cfg_wr;
    cmd_t                    cmd;

    logic                    tok_valid [PARTITIONS+1];
    logic                    tok_found [PARTITIONS+1];
    logic [IW-1:0]           tok_pick  [PARTITIONS+1];
    logic [SIZE_BITS-1:0]    tok_size  [PARTITIONS+1];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign in_mode   = s_tuser;
    assign in_pidx   = s_tdata[3:0];
    assign in_psize  = SIZE_BITS'(s_tdata[19:4]);
    assign in_req    = SIZE_BITS'(s_tdata[35:20]);
    assign scan_done = tok_valid[PARTITIONS];
    assign slot_free = !m_valid_reg || m_tready;

    assign cmd.load   = in_fire && !in_mode;
    assign cmd.grant  = scan_done && tok_found[PARTITIONS];
    assign cmd.policy = policy_reg;

    // Fresh search token enters the row in the cycle after the request is accepted
    assign tok_valid[0] = start_reg;
    assign tok_found[0] = 1'b0;
    assign tok_pick[0]  = '0;
    assign tok_size[0]  = '0;

    for (genvar i = 0; i < PARTITIONS; i++)
    begin : g_cell
        fpfa_cell #(
            .IDX       (i),
            .IW        (IW),
            .SIZE_BITS (SIZE_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .load_idx   (in_pidx),
            .load_size  (in_psize),
            .grant_idx  (tok_pick[PARTITIONS]),
            .lim        (parts_reg),
            .req        (req_reg),
            .tin_valid  (tok_valid[i]),
            .tin_found  (tok_found[i]),
            .tin_pick   (tok_pick[i]),
            .tin_size   (tok_size[i]),
            .tout_valid (tok_valid[i+1]),
            .tout_found (tok_found[i+1]),
            .tout_pick  (tok_pick[i+1]),
            .tout_size  (tok_size[i+1])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = in_mode ? ST_SCAN : ST_HOLD;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        m_valid_next = m_valid_reg && !m_tready;
        if ((state_reg == ST_HOLD) && slot_free)
        begin
            m_valid_next = 1'b1;
        end
    end

    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            policy_reg  <= FIT_FIRST;
            parts_reg   <= PARTS_W'(16);
        end
        else
        begin
            state_reg   <= state_next;
            start_reg   <= in_fire && in_mode;
            m_valid_reg <= m_valid_next;
            if (cfg_wr)
            begin
                case (paddr[2])
                    REG_FIT_POLICY: policy_reg <= fit_policy_t'(pwdata[1:0]);
                    REG_PARTS:      parts_reg  <= pwdata[PARTS_W-1:0];
                    default:        parts_reg  <= parts_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && in_mode)
        begin
            req_reg <= in_req;
        end
        if (cmd.load)
        begin
            res_granted_reg <= 1'b0;
            res_idx_reg     <= in_pidx;
            res_size_reg    <= '0;
        end
        else if (scan_done)
        begin
            res_granted_reg <= tok_found[PARTITIONS];
            res_idx_reg     <= tok_found[PARTITIONS] ? IN_IDX_W'(tok_pick[PARTITIONS]) : '0;
            res_size_reg    <= tok_found[PARTITIONS] ?
                               FIELD_SIZE_W'(tok_size[PARTITIONS]) : '0;
        end
        if ((state_reg == ST_HOLD) && slot_free)
        begin
            m_granted_reg <= res_granted_reg;
            m_idx_reg     <= res_idx_reg;
            m_size_reg    <= res_size_reg;
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_FIT_POLICY: prdata = {30'd0, policy_reg};
            REG_PARTS:      prdata = {27'd0, parts_reg};
            default:        prdata = '0;
        endcase
    end

    assign pready   = 1'b1;
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_granted_reg;
    assign m_tdata  = {4'd0, m_size_reg, m_idx_reg};

`ifndef SYNTHESIS
    a_token_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        scan_done |-> state_reg == ST_SCAN)
        else $error("search token left the row outside a scan");

    a_grant_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (scan_done && tok_found[PARTITIONS]) |-> tok_size[PARTITIONS] >= req_reg)
        else $error("granted partition smaller than request");

    a_no_start_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |-> !s_tready)
        else $error("input ready while a search starts");

    a_hold_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        scan_done |=> state_reg == ST_HOLD)
        else $error("finished search did not reach result hold");
`endif

endmodule
